FILE: design/dps_pkg.sv
// Package for the DDS parallel program sequencer.
// Holds field widths, command and action codes, register addresses and shared structs.
// No dependencies.
package dps_pkg;

    localparam int FUNC_W  = 2;
    localparam int FREQ_W  = 32;
    localparam int AMP_W   = 16;
    localparam int PLL_W   = 8;
    localparam int SCALE_W = 20;
    localparam int PROD_W  = FREQ_W + SCALE_W;
    localparam int FTW_W   = 48;
    localparam int ACT_W   = 2;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int STEP_W  = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SINE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    // Bus action codes
    localparam logic [ACT_W-1:0] ACT_RESET  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;

    // Configuration register indexes (word index of paddr)
    localparam logic [1:0] CFG_AMP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_PLL_MULT  = 2'd1;
    localparam logic [1:0] CFG_FTW_SCALE = 2'd2;

    localparam logic [AMP_W-1:0]   AMP_LIMIT_RST = 16'd4095;
    localparam logic [PLL_W-1:0]   PLL_MULT_RST  = 8'd15;
    localparam logic [SCALE_W-1:0] FTW_SCALE_RST = 20'd938250;

    // Chip register addresses
    localparam logic [ADDR_W-1:0] ADDR_FTW0   = 6'h04;
    localparam logic [ADDR_W-1:0] ADDR_FTW1   = 6'h05;
    localparam logic [ADDR_W-1:0] ADDR_FTW2   = 6'h06;
    localparam logic [ADDR_W-1:0] ADDR_FTW3   = 6'h07;
    localparam logic [ADDR_W-1:0] ADDR_FTW4   = 6'h08;
    localparam logic [ADDR_W-1:0] ADDR_FTW5   = 6'h09;
    localparam logic [ADDR_W-1:0] ADDR_CR_1D  = 6'h1D;
    localparam logic [ADDR_W-1:0] ADDR_CR_1E  = 6'h1E;
    localparam logic [ADDR_W-1:0] ADDR_CR_1F  = 6'h1F;
    localparam logic [ADDR_W-1:0] ADDR_CR_20  = 6'h20;
    localparam logic [ADDR_W-1:0] ADDR_AMP_IH = 6'h21;
    localparam logic [ADDR_W-1:0] ADDR_AMP_IL = 6'h22;
    localparam logic [ADDR_W-1:0] ADDR_AMP_QH = 6'h23;
    localparam logic [ADDR_W-1:0] ADDR_AMP_QL = 6'h24;
    localparam logic [ADDR_W-1:0] ADDR_NONE   = 6'h00;

    localparam logic [DATA_W-1:0] CR_20_VALUE = 8'h60;
    localparam logic [DATA_W-1:0] DATA_ZERO   = 8'h00;

    typedef struct packed {
        logic [AMP_W-1:0]   amp_limit;
        logic [PLL_W-1:0]   pll_multiplier;
        logic [SCALE_W-1:0] ftw_scale;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [FTW_W-1:0]  ftw;
        logic [AMP_W-1:0]  amp;
    } cmd_t;

endpackage

FILE: design/dps_cfg_regs.sv
// APB-style configuration registers of the DDS program sequencer.
// Depends on dps_pkg.
module dps_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dps_pkg::PADDR_W-1:0] paddr,
    input  logic [dps_pkg::PDATA_W-1:0] pwdata,
    output logic [dps_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output dps_pkg::cfg_t               cfg
);
    import dps_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[PADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (widx)
                CFG_AMP_LIMIT: cfg_next.amp_limit      = pwdata[AMP_W-1:0];
                CFG_PLL_MULT:  cfg_next.pll_multiplier = pwdata[PLL_W-1:0];
                CFG_FTW_SCALE: cfg_next.ftw_scale      = pwdata[SCALE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.amp_limit      <= AMP_LIMIT_RST;
            cfg_reg.pll_multiplier <= PLL_MULT_RST;
            cfg_reg.ftw_scale      <= FTW_SCALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (widx)
            CFG_AMP_LIMIT: prdata = {{(PDATA_W-AMP_W){1'b0}}, cfg_reg.amp_limit};
            CFG_PLL_MULT:  prdata = {{(PDATA_W-PLL_W){1'b0}}, cfg_reg.pll_multiplier};
            CFG_FTW_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg_reg.ftw_scale};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/dps_calc.sv
// Input register of the DDS program sequencer: holds one command, forms the
// tuning word product and clamps the amplitude. Depends on dps_pkg.
module dps_calc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dps_pkg::FUNC_W-1:0]  s_func,
    input  logic [dps_pkg::FREQ_W-1:0]  s_freq_hz,
    input  logic [dps_pkg::AMP_W-1:0]   s_amplitude,
    input  logic [dps_pkg::AMP_W-1:0]   amp_limit,
    input  logic [dps_pkg::SCALE_W-1:0] ftw_scale,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output dps_pkg::cmd_t               cmd
);
    import dps_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [FUNC_W-1:0] func_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic              rsvd;
    logic              take;
    logic              load;
    logic [PROD_W-1:0] product;

    // Reserved code is consumed here and produces nothing downstream.
    assign rsvd      = (func_reg == FUNC_RSVD);
    assign take      = in_valid_reg && (rsvd || cmd_ready);
    assign s_ready   = !in_valid_reg || take;
    assign load      = s_valid && s_ready;
    assign cmd_valid = in_valid_reg && !rsvd;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            func_reg <= s_func;
            freq_reg <= s_freq_hz;
            amp_reg  <= s_amplitude;
        end
    end

    // 32x20 product; bits above the tuning word are dropped.
    assign product  = PROD_W'(freq_reg) * PROD_W'(ftw_scale);
    assign cmd.func = func_reg;
    assign cmd.ftw  = product[FTW_W-1:0];
    assign cmd.amp  = (amp_reg > amp_limit) ? amp_limit : amp_reg;

endmodule

FILE: design/dps_emit.sv
// Action sequencer of the DDS program sequencer: steps through the run of one
// command and drives the result register. Depends on dps_pkg.
module dps_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  dps_pkg::cmd_t              cmd,
    input  logic [dps_pkg::PLL_W-1:0]  pll_multiplier,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dps_pkg::ACT_W-1:0]  m_action,
    output logic [dps_pkg::ADDR_W-1:0] m_reg_addr,
    output logic [dps_pkg::DATA_W-1:0] m_reg_data,
    output logic                       m_last
);
    import dps_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    cmd_t              cur_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [ACT_W-1:0]  act_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;

    logic              out_adv;
    logic              fire;
    logic              done;
    logic              load;
    logic [ACT_W-1:0]  act_c;
    logic [ADDR_W-1:0] addr_c;
    logic [DATA_W-1:0] data_c;
    logic              last_c;
    logic [DATA_W-1:0] amp_hi;
    logic [DATA_W-1:0] amp_lo;

    assign out_adv   = !m_valid_reg || m_ready;
    assign fire      = busy_reg && out_adv;
    assign done      = fire && last_c;
    assign cmd_ready = !busy_reg || done;
    assign load      = cmd_valid && cmd_ready;

    assign amp_hi = cur_reg.amp[AMP_W-1:DATA_W];
    assign amp_lo = cur_reg.amp[DATA_W-1:0];

    // Action for the current step of the run.
    always_comb begin
        act_c  = ACT_WRITE;
        addr_c = ADDR_NONE;
        data_c = DATA_ZERO;
        last_c = 1'b0;
        case (cur_reg.func)
            FUNC_INIT: begin
                case (step_reg)
                    4'd0: act_c = ACT_RESET;
                    4'd1: addr_c = ADDR_CR_1D;
                    4'd2: begin
                        addr_c = ADDR_CR_1E;
                        data_c = pll_multiplier;
                    end
                    4'd3: addr_c = ADDR_CR_1F;
                    4'd4: begin
                        addr_c = ADDR_CR_20;
                        data_c = CR_20_VALUE;
                    end
                    default: begin
                        act_c  = ACT_UPDATE;
                        last_c = 1'b1;
                    end
                endcase
            end
            FUNC_SINE: begin
                case (step_reg)
                    4'd0: begin
                        addr_c = ADDR_FTW0;
                        data_c = cur_reg.ftw[47:40];
                    end
                    4'd1: begin
                        addr_c = ADDR_FTW1;
                        data_c = cur_reg.ftw[39:32];
                    end
                    4'd2: begin
                        addr_c = ADDR_FTW2;
                        data_c = cur_reg.ftw[31:24];
                    end
                    4'd3: begin
                        addr_c = ADDR_FTW3;
                        data_c = cur_reg.ftw[23:16];
                    end
                    4'd4: begin
                        addr_c = ADDR_FTW4;
                        data_c = cur_reg.ftw[15:8];
                    end
                    4'd5: begin
                        addr_c = ADDR_FTW5;
                        data_c = cur_reg.ftw[7:0];
                    end
                    4'd6: begin
                        addr_c = ADDR_AMP_IH;
                        data_c = amp_hi;
                    end
                    4'd7: begin
                        addr_c = ADDR_AMP_IL;
                        data_c = amp_lo;
                    end
                    4'd8: begin
                        addr_c = ADDR_AMP_QH;
                        data_c = amp_hi;
                    end
                    4'd9: begin
                        addr_c = ADDR_AMP_QL;
                        data_c = amp_lo;
                    end
                    default: begin
                        act_c  = ACT_UPDATE;
                        last_c = 1'b1;
                    end
                endcase
            end
            FUNC_STOP: begin
                case (step_reg)
                    4'd0: addr_c = ADDR_AMP_IH;
                    4'd1: addr_c = ADDR_AMP_IL;
                    4'd2: addr_c = ADDR_AMP_QH;
                    4'd3: addr_c = ADDR_AMP_QL;
                    default: begin
                        act_c  = ACT_UPDATE;
                        last_c = 1'b1;
                    end
                endcase
            end
            default: begin
                // reserved code never reaches here; close the run anyway
                act_c  = ACT_UPDATE;
                last_c = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (load) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (fire) begin
            step_next = step_reg + 1'b1;
        end
        m_valid_next = out_adv ? fire : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= cmd;
        end
        if (fire) begin
            act_reg  <= act_c;
            addr_reg <= addr_c;
            data_reg <= data_c;
            last_reg <= last_c;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_action   = act_reg;
    assign m_reg_addr = addr_reg;
    assign m_reg_data = data_reg;
    assign m_last     = last_reg;

endmodule

FILE: design/dds_parallel_program_sequencer.sv
// Top level of the DDS parallel program sequencer.
// Depends on dps_pkg, dps_cfg_regs, dps_calc and dps_emit.
//
// Turns one command transfer (init, set sine, stop) into the run of bus
// actions a parallel-bus DDS chip needs, one action transfer per cycle
// while m_ready is high: init gives 6 actions, set sine 11, stop 5, the
// last one flagged by m_last. Throughput is set by the result register;
// while a run occupies the output, the next command waits in the input
// register. A command passes the input register and the command register
// of dps_emit before its first action reaches the result register.
// Reserved command code 3 is consumed in the input register and produces
// no action. The tuning word is the low 48 bits of freq_hz * ftw_scale
// (one 32x20 multiply in the input register stage); amplitude is clamped
// to amp_limit. Config registers (amp_limit @0x0, pll_multiplier @0x4,
// ftw_scale @0x8) must only be written while no command is in flight.
module dds_parallel_program_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dps_pkg::PADDR_W-1:0] paddr,
    input  logic [dps_pkg::PDATA_W-1:0] pwdata,
    output logic [dps_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // command channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dps_pkg::FUNC_W-1:0]  s_func,
    input  logic [dps_pkg::FREQ_W-1:0]  s_freq_hz,
    input  logic [dps_pkg::AMP_W-1:0]   s_amplitude,
    // action channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dps_pkg::ACT_W-1:0]   m_action,
    output logic [dps_pkg::ADDR_W-1:0]  m_reg_addr,
    output logic [dps_pkg::DATA_W-1:0]  m_reg_data,
    output logic                        m_last
);
    import dps_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    dps_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, tuning word multiply, amplitude clamp
    dps_calc u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_freq_hz   (s_freq_hz),
        .s_amplitude (s_amplitude),
        .amp_limit   (cfg.amp_limit),
        .ftw_scale   (cfg.ftw_scale),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    // step counter and result register
    dps_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .pll_multiplier (cfg.pll_multiplier),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_reg_addr     (m_reg_addr),
        .m_reg_data     (m_reg_data),
        .m_last         (m_last)
    );

`ifndef SYNTH
    // every run closes on the update pulse, and only there
    a_last_is_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_action == ACT_UPDATE)))
        else $error("last flag and update pulse disagree");

    // address and data are zero unless the action is a byte write
    a_nonwrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action != ACT_WRITE)) |-> ((m_reg_addr == ADDR_NONE)
        && (m_reg_data == DATA_ZERO)))
        else $error("pulse action carries address or data");

    // a reset pulse only opens a run: the previous action was a last one
    a_reset_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !(m_valid && (m_action == ACT_RESET)))
        else $error("reset pulse inside a run");

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

FILE: sim/tb_dds_parallel_program_sequencer.sv
// Testbench for dds_parallel_program_sequencer: directed commands, then random phases.
// Bus actions are predicted per command and checked in order; depends on dps_pkg.
module tb_dds_parallel_program_sequencer;
    import dps_pkg::*;

    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off for backpressure
    localparam int SETTLE_CYCLES = 8;        // covers a reserved command still in flight
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_CMDS    = 64;       // commands with actions per random phase
    localparam int N_PHASES      = 6;
    localparam int IDLE_PCT      = 23;
    localparam int MAX_PRINTS    = 100;
    localparam int DIR_N         = 14;

    // one bus action as it leaves the block
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } bus_act_t;

    // how a directed row gets its expected actions
    typedef enum logic [1:0] {
        CHK_MODEL,      // from the predictor
        CHK_INIT_RST,   // init with reset config, typed in
        CHK_STOP,       // stop run, typed in
        CHK_NONE        // reserved code, nothing comes out
    } chk_kind_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
        chk_kind_t         chk;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [FREQ_W-1:0]   s_freq_hz;
    logic [AMP_W-1:0]    s_amplitude;
    logic                m_valid;
    logic                m_ready;
    logic [ACT_W-1:0]    m_action;
    logic [ADDR_W-1:0]   m_reg_addr;
    logic [DATA_W-1:0]   m_reg_data;
    logic                m_last;

    // shadow copy of the configuration registers
    logic [AMP_W-1:0]    amp_limit_q;
    logic [PLL_W-1:0]    pll_mult_q;
    logic [SCALE_W-1:0]  ftw_scale_q;

    bus_act_t            pending_actions[$];
    int                  n_errors;
    bit                  src_idle_en;
    bit                  sink_idle_en;
    bit                  hold_req;

    // Directed commands, all issued with the reset configuration.
    dir_row_t dir_tab [DIR_N] = '{
        '{FUNC_INIT, 32'h0000_0000, 16'h0000, CHK_INIT_RST},
        '{FUNC_STOP, 32'hFFFF_FFFF, 16'hFFFF, CHK_STOP},
        '{FUNC_RSVD, 32'h1234_5678, 16'h9ABC, CHK_NONE},
        '{FUNC_SINE, 32'h0000_0000, 16'h0000, CHK_MODEL},
        '{FUNC_SINE, 32'hFFFF_FFFF, 16'hFFFF, CHK_MODEL},   // clamp, tuning word wraps
        '{FUNC_SINE, 32'h0000_0001, 16'd4095, CHK_MODEL},   // exactly at the limit
        '{FUNC_SINE, 32'd1000000,   16'd4096, CHK_MODEL},   // one above the limit
        '{FUNC_SINE, 32'h8000_0000, 16'h8000, CHK_MODEL},
        '{FUNC_SINE, 32'h5555_5555, 16'hAAAA, CHK_MODEL},
        '{FUNC_SINE, 32'hAAAA_AAAA, 16'h0555, CHK_MODEL},
        '{FUNC_RSVD, 32'hFFFF_FFFF, 16'hFFFF, CHK_NONE},
        '{FUNC_STOP, 32'h0000_0000, 16'h0000, CHK_STOP},
        '{FUNC_INIT, 32'hDEAD_BEEF, 16'h1234, CHK_MODEL},
        '{FUNC_SINE, 32'd100,       16'd4094, CHK_MODEL}
    };

    dds_parallel_program_sequencer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_freq_hz   (s_freq_hz),
        .s_amplitude (s_amplitude),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_action    (m_action),
        .m_reg_addr  (m_reg_addr),
        .m_reg_data  (m_reg_data),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        n_errors++;
    endtask

    function automatic void queue_action(input logic [ACT_W-1:0] act,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [DATA_W-1:0] data,
                                         input logic last);
        bus_act_t a;
        a.action = act;
        a.addr   = addr;
        a.data   = data;
        a.last   = last;
        pending_actions.push_back(a);
    endfunction

    // Bus actions one command produces under the current shadow config.
    function automatic void predict_actions(input logic [FUNC_W-1:0] func,
                                            input logic [FREQ_W-1:0] freq,
                                            input logic [AMP_W-1:0] amp);
        logic [PROD_W-1:0] prod;
        logic [FTW_W-1:0]  ftw;
        logic [AMP_W-1:0]  amp_c;
        case (func)
            FUNC_INIT: begin
                queue_action(ACT_RESET, ADDR_NONE, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_CR_1D, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_CR_1E, pll_mult_q, 1'b0);
                queue_action(ACT_WRITE, ADDR_CR_1F, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_CR_20, CR_20_VALUE, 1'b0);
                queue_action(ACT_UPDATE, ADDR_NONE, DATA_ZERO, 1'b1);
            end
            FUNC_SINE: begin
                // full 52-bit product, top bits dropped
                prod  = PROD_W'(freq) * PROD_W'(ftw_scale_q);
                ftw   = prod[FTW_W-1:0];
                amp_c = (amp > amp_limit_q) ? amp_limit_q : amp;
                for (int i = 0; i < 6; i++) begin
                    queue_action(ACT_WRITE, ADDR_FTW0 + ADDR_W'(i), ftw[8*(5-i) +: 8], 1'b0);
                end
                queue_action(ACT_WRITE, ADDR_AMP_IH, amp_c[15:8], 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_IL, amp_c[7:0], 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_QH, amp_c[15:8], 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_QL, amp_c[7:0], 1'b0);
                queue_action(ACT_UPDATE, ADDR_NONE, DATA_ZERO, 1'b1);
            end
            FUNC_STOP: begin
                queue_action(ACT_WRITE, ADDR_AMP_IH, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_IL, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_QH, DATA_ZERO, 1'b0);
                queue_action(ACT_WRITE, ADDR_AMP_QL, DATA_ZERO, 1'b0);
                queue_action(ACT_UPDATE, ADDR_NONE, DATA_ZERO, 1'b1);
            end
            default: begin
                // reserved code: consumed silently
            end
        endcase
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_AMP_LIMIT: amp_limit_q = val[AMP_W-1:0];
            CFG_PLL_MULT:  pll_mult_q  = val[PLL_W-1:0];
            CFG_FTW_SCALE: ftw_scale_q = val[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // One command transfer. Valid stays up across back-to-back transfers;
    // a random gap drops it first.
    task automatic send_cmd(input logic [FUNC_W-1:0] func,
                            input logic [FREQ_W-1:0] freq,
                            input logic [AMP_W-1:0] amp);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_freq_hz   <= freq;
        s_amplitude <= amp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait out all in-flight work before touching config.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !(sink_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Checker: every action transfer against the oldest expectation.
    always @(posedge aclk) begin
        bus_act_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_action, m_reg_addr, m_reg_data, m_last};
            if (pending_actions.size() == 0) begin
                flag_error($sformatf("unexpected action act=%0d addr=%0h data=%0h last=%0b",
                                     m_action, m_reg_addr, m_reg_data, m_last));
            end else begin
                want = pending_actions.pop_front();
                if (got.action !== want.action || got.addr !== want.addr ||
                    got.data !== want.data || got.last !== want.last) begin
                    flag_error($sformatf(
                        "got act=%0d addr=%0h data=%0h last=%0b, want %0d %0h %0h %0b",
                        got.action, got.addr, got.data, got.last,
                        want.action, want.addr, want.data, want.last));
                end
            end
        end
    end

    initial begin : stim
        logic [FUNC_W-1:0] func;
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
        int                r;
        int                n_cmds;

        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_func       = FUNC_INIT;
        s_freq_hz    = '0;
        s_amplitude  = '0;
        n_errors     = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        amp_limit_q  = AMP_LIMIT_RST;
        pll_mult_q   = PLL_MULT_RST;
        ftw_scale_q  = FTW_SCALE_RST;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset configuration
        for (int i = 0; i < DIR_N; i++) begin
            send_cmd(dir_tab[i].func, dir_tab[i].freq, dir_tab[i].amp);
            case (dir_tab[i].chk)
                CHK_INIT_RST: begin
                    queue_action(ACT_RESET, ADDR_NONE, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_CR_1D, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_CR_1E, 8'h0F, 1'b0);
                    queue_action(ACT_WRITE, ADDR_CR_1F, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_CR_20, 8'h60, 1'b0);
                    queue_action(ACT_UPDATE, ADDR_NONE, 8'h00, 1'b1);
                end
                CHK_STOP: begin
                    queue_action(ACT_WRITE, ADDR_AMP_IH, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_AMP_IL, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_AMP_QH, 8'h00, 1'b0);
                    queue_action(ACT_WRITE, ADDR_AMP_QL, 8'h00, 1'b0);
                    queue_action(ACT_UPDATE, ADDR_NONE, 8'h00, 1'b1);
                end
                CHK_NONE: ;
                default: predict_actions(dir_tab[i].func, dir_tab[i].freq, dir_tab[i].amp);
            endcase
        end

        // Random phases: 0 reset config, 1 all max, 2 all zero, then random.
        // Phase 3 carries the long receiver hold-off, phase 4 runs gap-free.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: ;
                1: begin
                    cfg_write(CFG_AMP_LIMIT, 32'hFFFF_FFFF);
                    cfg_write(CFG_PLL_MULT,  32'hFFFF_FFFF);
                    cfg_write(CFG_FTW_SCALE, 32'hFFFF_FFFF);
                end
                2: begin
                    cfg_write(CFG_AMP_LIMIT, 32'h0);
                    cfg_write(CFG_PLL_MULT,  32'h0);
                    cfg_write(CFG_FTW_SCALE, 32'h0);
                end
                default: begin
                    cfg_write(CFG_AMP_LIMIT, $urandom());
                    cfg_write(CFG_PLL_MULT,  $urandom());
                    cfg_write(CFG_FTW_SCALE, $urandom());
                end
            endcase
            src_idle_en  = (ph != 4);
            sink_idle_en = (ph != 4);
            if (ph == 3) hold_req = 1'b1;

            n_cmds = 0;
            while (n_cmds < PHASE_CMDS) begin
                r = $urandom_range(0, 99);
                if (r < 8)       func = FUNC_RSVD;
                else if (r < 22) func = FUNC_INIT;
                else if (r < 36) func = FUNC_STOP;
                else             func = FUNC_SINE;
                freq = ($urandom_range(0, 3) == 0) ? FREQ_W'($urandom_range(0, 1000))
                                                   : FREQ_W'($urandom());
                // bias amplitude around the clamp point
                case ($urandom_range(0, 4))
                    0:       amp = amp_limit_q;
                    1:       amp = amp_limit_q + 16'd1;
                    2:       amp = amp_limit_q - 16'd1;
                    default: amp = AMP_W'($urandom());
                endcase
                send_cmd(func, freq, amp);
                predict_actions(func, freq, amp);
                if (func != FUNC_RSVD) n_cmds++;
            end
        end

        // drain, then allow stray actions to show up
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
